FILE: rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared types and constants of the control frame deframer
// Header layout, status codes, configuration bundle and queue entry format.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // header geometry
    localparam int HEADER_BYTES = 36;
    localparam int HDR_BITS     = 8 * HEADER_BYTES;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

    // byte position counter, saturating at all ones
    localparam int POS_W = 33;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_MSK = 2'd3;

    localparam logic [31:0] MAGIC_RST   = 32'd0;
    localparam logic [15:0] VERSION_RST = 16'd1;
    localparam logic [31:0] MAX_LEN_RST = 32'd1048576;
    localparam logic [15:0] TYPE_RST    = 16'd0;

    // front/back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result stream
    localparam int OUT_DATA_W = 256;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_TRUNC_HDR   = 4'd1,
        ST_BAD_MAGIC   = 4'd2,
        ST_BAD_VERSION = 4'd3,
        ST_BAD_TYPE    = 4'd4,
        ST_TOO_LARGE   = 4'd5,
        ST_TRUNC_PAY   = 4'd6,
        ST_TRAILING    = 4'd7,
        ST_ZERO_ID     = 4'd8
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] protocol_version;
        logic [31:0] max_payload_len;
        logic [15:0] known_type_mask;
    } cfg_t;

    // decoded header, little-endian byte order
    typedef struct packed {
        logic [31:0] payload_len;
        logic [63:0] generation;
        logic [63:0] sess_ident;
        logic [63:0] req_ident;
        logic [15:0] message_type;
        logic [15:0] version;
        logic [31:0] magic;
    } header_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] message_type;
        logic [63:0] req_ident;
        logic [63:0] sess_ident;
        logic [63:0] generation;
        logic [31:0] payload_len;
    } verdict_t;

    // one entry per accepted byte that yields at least one result
    typedef struct packed {
        logic        has_payload;
        logic [7:0]  payload_byte;
        logic        is_verdict;
        verdict_t    verdict;
    } queue_entry_t;

endpackage

FILE: rtl/cfd_front.sv
// ----------------------------------------------------------------------------
// cfd_front: byte intake and classification
// Tracks the byte position, captures the header, runs the header checks and
// pushes one queue entry for each byte that produces results.
// ----------------------------------------------------------------------------
module cfd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfd_pkg::cfg_t        cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // last_byte
    input  logic                 q_full,
    output logic                 q_push,
    output cfd_pkg::queue_entry_t q_entry
);

    logic [cfd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [cfd_pkg::HDR_BITS-1:0] hdr_reg, hdr_next;
    logic [cfd_pkg::POS_W-1:0]    count;
    logic [cfd_pkg::POS_W-1:0]    frame_len;
    logic                         in_header;
    logic                         accept;
    logic                         pass_byte;
    cfd_pkg::header_t             hdr;
    cfd_pkg::status_t             hdr_status;
    cfd_pkg::verdict_t            verdict;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // header view including the byte arriving now
    assign in_header = pos_reg < cfd_pkg::POS_W'(cfd_pkg::HEADER_BYTES);

    always_comb begin
        hdr_next = hdr_reg;
        if (in_header) begin
            hdr_next[pos_reg[cfd_pkg::HDR_IDX_W-1:0]*8 +: 8] = s_tdata;
        end
    end

    assign hdr = cfd_pkg::header_t'(hdr_next);

    // magic, version, type and length checks in priority order
    always_comb begin
        if (hdr.magic != cfg.magic_word) begin
            hdr_status = cfd_pkg::ST_BAD_MAGIC;
        end else if (hdr.version != cfg.protocol_version) begin
            hdr_status = cfd_pkg::ST_BAD_VERSION;
        end else if (hdr.message_type[15:4] != '0 ||
                     !cfg.known_type_mask[hdr.message_type[3:0]]) begin
            hdr_status = cfd_pkg::ST_BAD_TYPE;
        end else if (hdr.payload_len > cfg.max_payload_len) begin
            hdr_status = cfd_pkg::ST_TOO_LARGE;
        end else begin
            hdr_status = cfd_pkg::ST_OK;
        end
    end

    // saturating byte count and expected frame length
    assign count     = (pos_reg == cfd_pkg::POS_MAX) ? cfd_pkg::POS_MAX : pos_reg + 1'b1;
    assign frame_len = cfd_pkg::POS_W'(cfd_pkg::HEADER_BYTES) +
                       cfd_pkg::POS_W'(hdr.payload_len);

    assign pass_byte = !in_header && hdr_status == cfd_pkg::ST_OK && pos_reg < frame_len;

    // verdict for the last byte of the buffer
    always_comb begin
        verdict = '0;
        if (count < cfd_pkg::POS_W'(cfd_pkg::HEADER_BYTES)) begin
            verdict.status = cfd_pkg::ST_TRUNC_HDR;
        end else begin
            if (hdr_status != cfd_pkg::ST_OK) begin
                verdict.status = hdr_status;
            end else if (count < frame_len) begin
                verdict.status = cfd_pkg::ST_TRUNC_PAY;
            end else if (count > frame_len) begin
                verdict.status = cfd_pkg::ST_TRAILING;
            end else if (hdr.req_ident == '0) begin
                verdict.status = cfd_pkg::ST_ZERO_ID;
            end else begin
                verdict.status = cfd_pkg::ST_OK;
            end
            verdict.message_type = hdr.message_type;
            verdict.req_ident    = hdr.req_ident;
            verdict.sess_ident   = hdr.sess_ident;
            verdict.generation   = hdr.generation;
            verdict.payload_len  = hdr.payload_len;
        end
    end

    always_comb begin
        q_entry              = '0;
        q_entry.has_payload  = pass_byte;
        q_entry.payload_byte = s_tdata;
        q_entry.is_verdict   = s_tlast;
        q_entry.verdict      = verdict;
    end

    assign q_push = accept && (pass_byte || s_tlast);

    // position restarts after the last byte
    assign pos_next = s_tlast ? '0 : count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    // header bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            hdr_reg <= hdr_next;
        end
    end

    // a finished buffer always leaves the position at zero
    a_pos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> pos_reg == '0)
        else $error("byte position not cleared after last byte");

    // every non-final byte advances the position unless the position is saturated
    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tlast && pos_reg != cfd_pkg::POS_MAX |=> pos_reg != '0)
        else $error("byte position lost within a buffer");

endmodule

FILE: rtl/cfd_queue.sv
// ----------------------------------------------------------------------------
// cfd_queue: short queue between front and back
// Register-based circular buffer of classified entries.
// ----------------------------------------------------------------------------
module cfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cfd_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output cfd_pkg::queue_entry_t head_entry
);

    cfd_pkg::queue_entry_t            entry_reg [cfd_pkg::QUEUE_DEPTH];
    logic [cfd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cfd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cfd_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full       = count_reg == cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == cfd_pkg::QPTR_W'(cfd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == cfd_pkg::QPTR_W'(cfd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

endmodule

FILE: rtl/cfd_back.sv
// ----------------------------------------------------------------------------
// cfd_back: result generation
// Expands each queue entry into a payload transfer, a verdict transfer or
// both, through a registered output stage.
// ----------------------------------------------------------------------------
module cfd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  cfd_pkg::queue_entry_t head_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [cfd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    logic                            phase_reg, phase_next;
    logic                            out_valid_reg, out_valid_next;
    cfd_pkg::kind_t                  out_kind_reg, out_kind_next;
    logic [cfd_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                            out_free;
    logic                            send_payload;
    cfd_pkg::verdict_t               v;

    assign out_free     = !out_valid_reg || m_tready;
    assign send_payload = head_entry.has_payload && !phase_reg;
    assign v            = head_entry.verdict;

    // choose the next transfer from the head entry
    always_comb begin
        pop            = 1'b0;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        if (head_valid && out_free) begin
            out_valid_next = 1'b1;
            if (send_payload) begin
                out_kind_next = cfd_pkg::KIND_PAYLOAD;
                out_data_next = cfd_pkg::OUT_DATA_W'(head_entry.payload_byte);
                if (head_entry.is_verdict) begin
                    phase_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                out_kind_next = cfd_pkg::KIND_VERDICT;
                out_data_next = cfd_pkg::OUT_DATA_W'({v.payload_len, v.generation,
                                                      v.sess_ident, v.req_ident,
                                                      v.message_type, v.status, 8'd0});
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // a queued entry always carries at least one result
    a_entry_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> head_entry.has_payload || head_entry.is_verdict)
        else $error("empty entry in queue");

    // the verdict half of an entry stays pending at the head
    a_phase_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> head_valid && head_entry.is_verdict)
        else $error("verdict phase without pending verdict");

endmodule

FILE: rtl/control_frame_deframer.sv
// ----------------------------------------------------------------------------
// control_frame_deframer: length-prefixed control frame parser
// Holds the configuration registers and joins intake, queue and output.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the encoded buffer one byte per transfer, s_tlast on its
//   final byte. The first 36 bytes form the little-endian header; payload
//   bytes that pass the header checks come out on m_* with m_tuser low,
//   and the final byte of each buffer yields a verdict transfer with
//   m_tuser high carrying the status and decoded header fields.
//   cfg_we/cfg_index/cfg_wdata write magic, version, max payload length
//   and known type mask; write them only while the block is idle.
//   Each result-carrying byte is queued when it is accepted; its result
//   then loads the output register once that register is free.
//   Throughput: one input byte per cycle; one result per cycle out while
//   m_tready is high, so a final byte that also passes payload yields a
//   payload transfer followed by a verdict transfer.
//   The input stalls only when the two-entry queue is full.
//   Reset clears the byte position, the queue and the output valid, and
//   loads the configuration defaults. When the receiver holds m_tready low
//   the output register keeps its transfer and the queue absorbs up to two
//   more result-carrying bytes before s_tready drops.
// ----------------------------------------------------------------------------
module control_frame_deframer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] payload_byte, [11:8] status, [27:12] message_type,
    // [91:28] req_ident, [155:92] sess_ident, [219:156] generation,
    // [251:220] payload_len, [255:252] zero
    output logic [cfd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser,   // item_kind
    input  logic                               cfg_we,
    input  logic [cfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    cfd_pkg::cfg_t         cfg_reg;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  head_valid;
    cfd_pkg::queue_entry_t push_entry;
    cfd_pkg::queue_entry_t head_entry;

    // configuration register bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word       <= cfd_pkg::MAGIC_RST;
            cfg_reg.protocol_version <= cfd_pkg::VERSION_RST;
            cfg_reg.max_payload_len  <= cfd_pkg::MAX_LEN_RST;
            cfg_reg.known_type_mask  <= cfd_pkg::TYPE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cfd_pkg::CFG_MAGIC:    cfg_reg.magic_word       <= cfg_wdata;
                cfd_pkg::CFG_VERSION:  cfg_reg.protocol_version <= cfg_wdata[15:0];
                cfd_pkg::CFG_MAX_LEN:  cfg_reg.max_payload_len  <= cfg_wdata;
                cfd_pkg::CFG_TYPE_MSK: cfg_reg.known_type_mask  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    cfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    cfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    cfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for control_frame_deframer
// Streams encoded control buffers into the deframer, one byte per transfer,
// and tracks the header parser in a cycle-free software copy. Every payload
// byte and verdict that leaves the block is compared field by field with the
// oldest pending prediction. A directed table of frames hits the reset
// defaults, each status code and the field extremes; random frames follow,
// mostly well formed with random content, some with one broken header field
// and some plain noise, under several register settings with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          PIPE_CYCLES  = 2;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          RAND_PHASES  = 4;
    localparam int          RAND_BYTES   = 160;
    localparam int          RAND_VERDICT = 6;
    localparam logic [31:0] DIR_MAGIC    = 32'hC0DE_F00D;
    localparam logic [15:0] DIR_VER      = 16'd3;
    localparam int          N_DIR        = 18;
    localparam int          N_RESET_ROWS = 2;
    localparam int          HOLD_ROW     = 11;

    // one expected result; fields follow the m_tdata/m_tuser layout
    typedef struct packed {
        cfd_pkg::kind_t   kind;
        logic [7:0]       payload_byte;
        cfd_pkg::status_t status;
        logic [15:0]      message_type;
        logic [63:0]      req_ident;
        logic [63:0]      sess_ident;
        logic [63:0]      generation;
        logic [31:0]      payload_len;
    } frame_result_t;

    // one directed buffer: header fields, header cut (0 = full), payload count
    typedef struct packed {
        logic [31:0]      magic;
        logic [15:0]      version;
        logic [15:0]      mtype;
        logic [63:0]      req;
        logic [63:0]      sess;
        logic [63:0]      gen;
        logic [31:0]      plen;
        logic [5:0]       cut;
        logic [7:0]       n_pay;
        logic             pinned;
        cfd_pkg::status_t st;
    } frame_row_t;

    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam frame_row_t DIR_ROWS [N_DIR] = '{
        // reset defaults: type mask is zero, so even type 0 is unknown
        '{32'h0, 16'd1, 16'd0, 64'd1, 64'd2, 64'd3, 32'd0, 6'd0, 8'd0, 1'b1,
          cfd_pkg::ST_BAD_TYPE},
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd1, 64'd2, 64'd3, 32'd0, 6'd1, 8'd0, 1'b1,
          cfd_pkg::ST_TRUNC_HDR},
        // directed settings from here on
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd5, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210, 32'd4, 6'd0, 8'd4, 1'b0, cfd_pkg::ST_OK},
        '{DIR_MAGIC, DIR_VER, 16'd15, ONES64, ONES64, ONES64, 32'd0, 6'd0, 8'd0, 1'b1,
          cfd_pkg::ST_OK},
        '{DIR_MAGIC, DIR_VER, 16'd16, 64'd7, 64'd0, 64'd0, 32'd0, 6'd0, 8'd2, 1'b1,
          cfd_pkg::ST_BAD_TYPE},
        '{DIR_MAGIC, DIR_VER, 16'hFFFF, 64'd7, 64'd0, 64'd0, 32'd0, 6'd0, 8'd0, 1'b1,
          cfd_pkg::ST_BAD_TYPE},
        '{DIR_MAGIC, DIR_VER, 16'd1, 64'd7, 64'd0, 64'd0, 32'd0, 6'd0, 8'd0, 1'b1,
          cfd_pkg::ST_BAD_TYPE},
        // magic wins over a bad version and type
        '{DIR_MAGIC ^ 32'h8000_0000, 16'd0, 16'd16, 64'd7, 64'd1, 64'd1, 32'd0, 6'd0,
          8'd3, 1'b1, cfd_pkg::ST_BAD_MAGIC},
        '{DIR_MAGIC, 16'd2, 16'd16, 64'd7, 64'd1, 64'd1, 32'd0, 6'd0, 8'd3, 1'b1,
          cfd_pkg::ST_BAD_VERSION},
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd7, 64'd1, 64'd1, 32'd17, 6'd0, 8'd0, 1'b1,
          cfd_pkg::ST_TOO_LARGE},
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd7, 64'd1, 64'd1, 32'hFFFF_FFFF, 6'd0, 8'd2,
          1'b1, cfd_pkg::ST_TOO_LARGE},
        '{DIR_MAGIC, DIR_VER, 16'd15, 64'd8, 64'd9, 64'd10, 32'd16, 6'd0, 8'd16, 1'b1,
          cfd_pkg::ST_OK},
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd8, 64'd9, 64'd10, 32'd8, 6'd0, 8'd5, 1'b1,
          cfd_pkg::ST_TRUNC_PAY},
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd8, 64'd9, 64'd10, 32'd2, 6'd0, 8'd6, 1'b0,
          cfd_pkg::ST_TRAILING},
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd0, 64'd9, 64'd10, 32'd3, 6'd0, 8'd3, 1'b1,
          cfd_pkg::ST_ZERO_ID},
        // truncated payload outranks a zero request id
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd0, 64'd9, 64'd10, 32'd3, 6'd0, 8'd1, 1'b1,
          cfd_pkg::ST_TRUNC_PAY},
        '{DIR_MAGIC, DIR_VER, 16'd0, 64'd9, 64'd9, 64'd10, 32'd0, 6'd35, 8'd0, 1'b1,
          cfd_pkg::ST_TRUNC_HDR},
        '{32'h0, 16'd0, 16'd0, 64'd0, 64'd0, 64'd0, 32'd0, 6'd0, 8'd0, 1'b1,
          cfd_pkg::ST_BAD_MAGIC}
    };

    // DUT ports
    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;    // [7:0] data_byte
    logic                            s_tlast;    // last_byte
    logic                            m_tvalid;
    logic                            m_tready;
    // [7:0] payload_byte, [11:8] status, [27:12] message_type,
    // [91:28] req_ident, [155:92] sess_ident, [219:156] generation,
    // [251:220] payload_len, [255:252] zero
    logic [cfd_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tuser;    // item_kind
    logic                            cfg_we;
    logic [cfd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // shadow of the parser
    cfd_pkg::cfg_t             cfg_shadow;
    logic [cfd_pkg::POS_W-1:0] byte_pos;
    logic [7:0]                hdr_bytes [cfd_pkg::HEADER_BYTES];
    frame_result_t             pending_results [$];
    int                        pinned_status_q [$];

    // bookkeeping
    int   fail_count;
    int   bytes_sent;
    int   verdicts_predicted;
    int   payload_seen;
    int   verdicts_seen;
    int   settings_applied;
    logic [8:0] statuses_seen;
    int   burst_left;
    bit   sender_steady;
    bit   hold_off_req;

    control_frame_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // little-endian read of the header shadow
    function automatic logic [63:0] hdr_field(int off, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v[8*i +: 8] = hdr_bytes[off + i];
        return v;
    endfunction

    // magic, version, type and length checks in priority order
    function automatic cfd_pkg::status_t header_check();
        logic [15:0] mt;
        mt = 16'(hdr_field(6, 2));
        if (hdr_field(0, 4) != cfg_shadow.magic_word) return cfd_pkg::ST_BAD_MAGIC;
        if (hdr_field(4, 2) != cfg_shadow.protocol_version) return cfd_pkg::ST_BAD_VERSION;
        if (mt >= 16 || !cfg_shadow.known_type_mask[mt[3:0]]) return cfd_pkg::ST_BAD_TYPE;
        if (hdr_field(32, 4) > cfg_shadow.max_payload_len) return cfd_pkg::ST_TOO_LARGE;
        return cfd_pkg::ST_OK;
    endfunction

    // advance the shadow by one accepted byte and queue what it yields
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        logic [cfd_pkg::POS_W-1:0] idx;
        logic [cfd_pkg::POS_W-1:0] count;
        logic [63:0]               frame_len;
        frame_result_t             r;
        cfd_pkg::status_t          st;
        int                        pin;
        idx   = byte_pos;
        count = (idx == cfd_pkg::POS_MAX) ? cfd_pkg::POS_MAX : idx + 1'b1;
        if (idx < cfd_pkg::HEADER_BYTES) hdr_bytes[idx] = b;
        frame_len = 64'(cfd_pkg::HEADER_BYTES) + hdr_field(32, 4);

        if (idx >= cfd_pkg::HEADER_BYTES && header_check() == cfd_pkg::ST_OK &&
            64'(idx) < frame_len) begin
            r              = '0;
            r.kind         = cfd_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            pending_results.insert(pending_results.size(), r);
        end

        if (last) begin
            r      = '0;
            r.kind = cfd_pkg::KIND_VERDICT;
            if (count < cfd_pkg::HEADER_BYTES) begin
                st = cfd_pkg::ST_TRUNC_HDR;
            end else begin
                st = header_check();
                if (st == cfd_pkg::ST_OK) begin
                    if (64'(count) < frame_len) st = cfd_pkg::ST_TRUNC_PAY;
                    else if (64'(count) > frame_len) st = cfd_pkg::ST_TRAILING;
                    else if (hdr_field(8, 8) == 0) st = cfd_pkg::ST_ZERO_ID;
                end
                r.message_type = 16'(hdr_field(6, 2));
                r.req_ident    = hdr_field(8, 8);
                r.sess_ident   = hdr_field(16, 8);
                r.generation   = hdr_field(24, 8);
                r.payload_len  = 32'(hdr_field(32, 4));
            end
            // directed rows may carry a hand-typed status
            if (pinned_status_q.size() != 0) begin
                pin = pinned_status_q.pop_front();
                if (pin >= 0) st = cfd_pkg::status_t'(pin[3:0]);
            end
            r.status = st;
            pending_results.insert(pending_results.size(), r);
            verdicts_predicted++;
            byte_pos = '0;
        end else begin
            byte_pos = count;
        end
    endtask

    // input side monitor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) deframe_byte(s_tdata, s_tlast);
    end

    function automatic void check_field(string what, logic [63:0] exp_v,
                                        logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v,
                     act_v);
            fail_count++;
        end
    endfunction

    // result side checker
    always @(posedge aclk) begin
        frame_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tuser %0b tdata %0h",
                         $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("item_kind",    e.kind,         m_tuser);
                check_field("payload_byte", e.payload_byte, m_tdata[7:0]);
                check_field("status",       e.status,       m_tdata[11:8]);
                check_field("message_type", e.message_type, m_tdata[27:12]);
                check_field("req_ident",    e.req_ident,    m_tdata[91:28]);
                check_field("sess_ident",   e.sess_ident,   m_tdata[155:92]);
                check_field("generation",   e.generation,   m_tdata[219:156]);
                check_field("payload_len",  e.payload_len,  m_tdata[251:220]);
                if (e.kind == cfd_pkg::KIND_VERDICT) begin
                    verdicts_seen++;
                    statuses_seen[e.status] = 1'b1;
                end else begin
                    payload_seen++;
                end
            end
        end
    end

    // receiver: random stall patterns, plus a long hold-off on request
    initial begin
        int  mode;
        int  len;
        logic rdy;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(4, 40);
                repeat (len) begin
                    case (mode)
                        0:       rdy = 1'b1;
                        1:       rdy = $urandom_range(0, 1);
                        2:       rdy = ($urandom_range(0, 4) != 0);
                        default: rdy = ($urandom_range(0, 3) == 0);
                    endcase
                    m_tready <= rdy;
                    @(posedge aclk);
                    if (hold_off_req) break;
                end
            end
        end
    end

    // offer one byte, idling at burst boundaries, and wait for the transfer
    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = sender_steady ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // header bytes (possibly cut short), then payload bytes
    task automatic send_buffer(input cfd_pkg::header_t h, input int cut, input int n_pay,
                               input bit patterned);
        logic [cfd_pkg::HDR_BITS-1:0] hv;
        logic [7:0]                   b;
        int                           total;
        hv    = h;
        total = (cut > 0) ? cut : cfd_pkg::HEADER_BYTES + n_pay;
        for (int i = 0; i < total; i++) begin
            if (i < cfd_pkg::HEADER_BYTES) b = hv[8*i +: 8];
            else if (!patterned) b = 8'($urandom);
            else b = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'($urandom);
            put_byte(b, i == total - 1);
        end
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_CYCLES + 2) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [cfd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cfd_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [31:0] mg, input logic [15:0] ver,
                                input logic [31:0] mx, input logic [15:0] mask);
        reg_write(cfd_pkg::CFG_MAGIC,    mg);
        reg_write(cfd_pkg::CFG_VERSION,  {16'h0, ver});
        reg_write(cfd_pkg::CFG_MAX_LEN,  mx);
        reg_write(cfd_pkg::CFG_TYPE_MSK, {16'h0, mask});
        cfg_we <= 1'b0;
        cfg_shadow.magic_word       = mg;
        cfg_shadow.protocol_version = ver;
        cfg_shadow.max_payload_len  = mx;
        cfg_shadow.known_type_mask  = mask;
        settings_applied++;
    endtask

    // random buffer: well-formed frame, frame with one broken field, or noise
    task automatic random_buffer();
        cfd_pkg::header_t h;
        int               r;
        int               n;
        int               cut;
        int               n_pay;
        int               sel;
        logic [31:0]      cap;
        logic [15:0]      t;
        r = $urandom_range(0, 99);
        if (r >= 85) begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) put_byte(8'($urandom), i == n - 1);
            return;
        end

        h.magic   = cfg_shadow.magic_word;
        h.version = cfg_shadow.protocol_version;
        t = 16'($urandom_range(0, 15));
        if (cfg_shadow.known_type_mask != 0)
            while (!cfg_shadow.known_type_mask[t[3:0]]) t = 16'($urandom_range(0, 15));
        h.message_type = t;
        h.req_ident    = ($urandom_range(0, 15) == 0) ? 64'd0 : {$urandom, $urandom};
        h.sess_ident   = {$urandom, $urandom};
        h.generation   = {$urandom, $urandom};
        cap = (cfg_shadow.max_payload_len < 12) ? cfg_shadow.max_payload_len : 32'd12;
        h.payload_len = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                     : 32'($urandom_range(0, cap));
        n_pay = (h.payload_len > 12) ? $urandom_range(0, 12) : int'(h.payload_len);
        sel = $urandom_range(0, 5);
        if (sel == 0) n_pay += $urandom_range(1, 3);
        else if (sel == 1 && n_pay > 0) n_pay = $urandom_range(0, n_pay - 1);

        cut = 0;
        if (r >= 65) begin
            case ($urandom_range(0, 4))
                0:       h.magic ^= 32'h1 << $urandom_range(0, 31);
                1:       h.version ^= 16'h1 << $urandom_range(0, 15);
                2:       h.message_type = 16'($urandom);
                3:       h.payload_len = 32'(cfg_shadow.max_payload_len +
                                             $urandom_range(1, 36));
                default: cut = $urandom_range(1, 35);
            endcase
        end
        send_buffer(h, cut, n_pay, 1'b0);
    endtask

    // global time limit
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // main sequence
    initial begin
        cfd_pkg::header_t h;
        int               phase;
        int               phase_start;
        int               rand_verdict_base;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cfg_shadow.magic_word       = cfd_pkg::MAGIC_RST;
        cfg_shadow.protocol_version = cfd_pkg::VERSION_RST;
        cfg_shadow.max_payload_len  = cfd_pkg::MAX_LEN_RST;
        cfg_shadow.known_type_mask  = cfd_pkg::TYPE_RST;
        byte_pos = '0;
        for (int i = 0; i < cfd_pkg::HEADER_BYTES; i++) hdr_bytes[i] = 8'h00;
        fail_count = 0;
        bytes_sent = 0;
        verdicts_predicted = 0;
        payload_seen = 0;
        verdicts_seen = 0;
        settings_applied = 0;
        statuses_seen = '0;
        burst_left = 0;
        sender_steady = 1'b0;
        hold_off_req = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames; the first rows run on the reset defaults
        for (int i = 0; i < N_DIR; i++) begin
            if (i == N_RESET_ROWS) begin
                drain();
                write_config(DIR_MAGIC, DIR_VER, 32'd16, 16'h8001);
            end
            if (i == HOLD_ROW) hold_off_req = 1'b1;
            h.magic        = DIR_ROWS[i].magic;
            h.version      = DIR_ROWS[i].version;
            h.message_type = DIR_ROWS[i].mtype;
            h.req_ident    = DIR_ROWS[i].req;
            h.sess_ident   = DIR_ROWS[i].sess;
            h.generation   = DIR_ROWS[i].gen;
            h.payload_len  = DIR_ROWS[i].plen;
            pinned_status_q.insert(pinned_status_q.size(),
                                   DIR_ROWS[i].pinned ? int'(DIR_ROWS[i].st) : -1);
            send_buffer(h, DIR_ROWS[i].cut, DIR_ROWS[i].n_pay, 1'b1);
        end

        // random frames over several register settings
        rand_verdict_base = verdicts_predicted;
        for (phase = 0;
             phase < RAND_PHASES || verdicts_predicted - rand_verdict_base < RAND_VERDICT;
             phase++) begin
            drain();
            case (phase)
                0: write_config(32'hFFFF_FFFF, 16'hFFFF, 32'd4294967259, 16'hFFFF);
                1: write_config(32'h0, 16'h0, 32'h0, 16'h0001);
                default: write_config($urandom, 16'($urandom), $urandom_range(0, 24),
                                      16'($urandom) | (16'h1 << $urandom_range(0, 15)));
            endcase
            sender_steady = (phase % 3 == 2);
            if (phase == 0) hold_off_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RAND_BYTES / RAND_PHASES) random_buffer();
        end

        // wind down
        drain();
        repeat (PIPE_CYCLES + 8) @(posedge aclk);
        $display("Covered %0d input bytes under %0d register settings.", bytes_sent,
                 settings_applied);
        $display("Checked %0d payload transfers and %0d verdicts, status codes seen %b.",
                 payload_seen, verdicts_seen, statuses_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
